@@ rtl/core/tme_pkg.sv @@
// Shared types, constants and saturation helpers for the 4x4 transform
// matrix engine. No dependencies.
package tme_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int ACC_BITS  = WORD_BITS + 2;
	localparam int CNT_BITS  = 6;
	localparam int IO_BITS   = 32;
	localparam int WIDE_BITS = 64;

	typedef logic signed [WORD_BITS-1:0] elem_t;

	localparam elem_t ELEM_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WIDE_BITS-1:0] ONE_RAW = WIDE_BITS'(1) << FRAC_BITS;
	localparam elem_t ELEM_ONE = (FRAC_BITS <= WORD_BITS - 2) ?
		ONE_RAW[WORD_BITS-1:0] : ELEM_MAX;

	localparam logic [3:0] CMD_IDENTITY = 4'd0;
	localparam logic [3:0] CMD_WR_CUR   = 4'd1;
	localparam logic [3:0] CMD_WR_OPD   = 4'd2;
	localparam logic [3:0] CMD_SCALE    = 4'd3;
	localparam logic [3:0] CMD_XLATE    = 4'd4;
	localparam logic [3:0] CMD_PREMULT  = 4'd5;
	localparam logic [3:0] CMD_READ     = 4'd6;
	localparam logic [3:0] CMD_COMPARE  = 4'd7;
	localparam logic [3:0] CMD_COPY     = 4'd8;

	typedef struct packed {
		logic       issue;
		logic       first;
		logic       last;
		logic [3:0] dest;
	} mac_ctl_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] dest;
		elem_t      value;
	} mac_res_t;

	function automatic elem_t sat_prod(input logic signed [PROD_BITS-1:0] v);
		logic signed [PROD_BITS-1:0] hi;
		logic signed [PROD_BITS-1:0] lo;
		hi = PROD_BITS'(ELEM_MAX);
		lo = PROD_BITS'(ELEM_MIN);
		if (v > hi) begin
			return ELEM_MAX;
		end else if (v < lo) begin
			return ELEM_MIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	function automatic elem_t sat_acc(input logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] hi;
		logic signed [ACC_BITS-1:0] lo;
		hi = ACC_BITS'(ELEM_MAX);
		lo = ACC_BITS'(ELEM_MIN);
		if (v > hi) begin
			return ELEM_MAX;
		end else if (v < lo) begin
			return ELEM_MIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	function automatic elem_t in_to_elem(input logic signed [IO_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] w;
		w = WIDE_BITS'(v);
		if (w > WIDE_BITS'(ELEM_MAX)) begin
			return ELEM_MAX;
		end else if (w < WIDE_BITS'(ELEM_MIN)) begin
			return ELEM_MIN;
		end
		return w[WORD_BITS-1:0];
	endfunction

	function automatic logic signed [IO_BITS-1:0] elem_to_out(input elem_t e);
		logic signed [WIDE_BITS-1:0] w;
		logic signed [WIDE_BITS-1:0] hi;
		logic signed [WIDE_BITS-1:0] lo;
		w  = WIDE_BITS'(e);
		hi = WIDE_BITS'({1'b0, {(IO_BITS-1){1'b1}}});
		lo = -hi - WIDE_BITS'(1);
		if (w > hi) begin
			w = hi;
		end else if (w < lo) begin
			w = lo;
		end
		return w[IO_BITS-1:0];
	endfunction

endpackage

@@ rtl/core/tme_mac.sv @@
// Shared fixed point multiply-accumulate unit: registered product, then
// floor shift, product saturation, accumulate and sum saturation.
// Depends on tme_pkg.
module tme_mac import tme_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_ctl_t ctl,
	input  elem_t    op_a,
	input  elem_t    op_b,
	output mac_res_t res
);

	logic signed [PROD_BITS-1:0] prod_s1;
	mac_ctl_t                    ctl_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [PROD_BITS-1:0] shifted;
	elem_t                       term;
	logic signed [ACC_BITS-1:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
		if (ctl_s1.issue) begin
			acc_q <= sum;
		end
	end

	always_comb begin
		shifted = prod_s1 >>> FRAC_BITS;
		term    = sat_prod(shifted);
		sum     = (ctl_s1.first ? ACC_BITS'(0) : acc_q) + ACC_BITS'(term);
	end

	assign res.valid = ctl_s1.issue & ctl_s1.last;
	assign res.dest  = ctl_s1.dest;
	assign res.value = sat_acc(sum);

endmodule

@@ rtl/core/transform_matrix_4x4_engine.sv @@
// 4x4 transform matrix engine top level: command sequencer, current,
// operand and scratch matrices, output register.
// Depends on tme_pkg and tme_mac.
//
// Input channel (in_valid/in_stall) takes one command word; output channel
// (out_valid/out_stall) returns one result word per command.
// Element write, read, identity, copy and unused codes finish at accept;
// the result is in the output register on the next cycle.
// Scale takes 12 MAC issues, translate 16, premultiply 64 (4 per element);
// compare walks 16 element pairs. Each then passes through ST_DRAIN, where
// the MAC pipeline drains, and ST_DONE, where the result is posted.
// The single shared MAC (one product per cycle) serialises these issues.
// One command is in work at a time; in_stall is high while busy and
// while a posted result is held by out_stall.
// A stalled result holds its value until taken.
// Reset zeroes the current and operand matrices and the output register.
module transform_matrix_4x4_engine import tme_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [3:0]                command,
	input  logic [1:0]                row,
	input  logic [1:0]                col,
	input  logic signed [IO_BITS-1:0] value,
	input  logic signed [IO_BITS-1:0] vec_x,
	input  logic signed [IO_BITS-1:0] vec_y,
	input  logic signed [IO_BITS-1:0] vec_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [IO_BITS-1:0] read_value,
	output logic                      matrices_equal
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [CNT_BITS-1:0] LAST_PREMULT = CNT_BITS'(63);
	localparam logic [CNT_BITS-1:0] LAST_SCALE   = CNT_BITS'(11);
	localparam logic [CNT_BITS-1:0] LAST_WALK    = CNT_BITS'(15);

	logic [1:0]          state_q;
	logic [3:0]          cmd_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] run_last;
	logic                eq_q;
	logic                out_valid_q;
	logic signed [IO_BITS-1:0] read_q;
	logic                equal_q;

	elem_t cur_q [16];
	elem_t opd_q [16];
	elem_t tmp_q [16];
	elem_t vec_q [4];

	logic       out_free;
	logic       accept;
	logic       is_long;
	logic       finish;
	logic [3:0] idx;
	logic [3:0] cur_addr;
	logic [3:0] opd_addr;
	elem_t      cur_rd;
	elem_t      opd_rd;
	elem_t      mac_a;
	elem_t      mac_b;
	mac_ctl_t   mac_ctl;
	mac_res_t   mac_res;

	assign idx      = {row, col};
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign is_long  = (command == CMD_SCALE) || (command == CMD_XLATE) ||
		(command == CMD_PREMULT) || (command == CMD_COMPARE);

	assign out_valid      = out_valid_q;
	assign read_value     = read_q;
	assign matrices_equal = equal_q;

	always_comb begin
		unique case (cmd_q)
			CMD_PREMULT: run_last = LAST_PREMULT;
			CMD_SCALE:   run_last = LAST_SCALE;
			default:     run_last = LAST_WALK;
		endcase
	end

	// read port addresses and MAC issue
	always_comb begin
		cur_addr = idx;
		opd_addr = cnt_q[3:0];
		mac_ctl  = '0;
		mac_a    = cur_rd;
		mac_b    = vec_q[cnt_q[1:0]];
		if (state_q == ST_RUN) begin
			unique case (cmd_q)
				CMD_PREMULT: begin
					cur_addr      = {cnt_q[1:0], cnt_q[3:2]};
					opd_addr      = {cnt_q[5:4], cnt_q[1:0]};
					mac_a         = opd_rd;
					mac_b         = cur_rd;
					mac_ctl.issue = 1'b1;
					mac_ctl.first = cnt_q[1:0] == 2'd0;
					mac_ctl.last  = cnt_q[1:0] == 2'd3;
					mac_ctl.dest  = {cnt_q[5:4], cnt_q[3:2]};
				end
				CMD_SCALE: begin
					cur_addr      = cnt_q[3:0];
					mac_b         = vec_q[cnt_q[3:2]];
					mac_ctl.issue = 1'b1;
					mac_ctl.first = 1'b1;
					mac_ctl.last  = 1'b1;
					mac_ctl.dest  = cnt_q[3:0];
				end
				CMD_XLATE: begin
					// fourth term is old row 3 times 1.0
					cur_addr      = {cnt_q[1:0], cnt_q[3:2]};
					mac_ctl.issue = 1'b1;
					mac_ctl.first = cnt_q[1:0] == 2'd0;
					mac_ctl.last  = cnt_q[1:0] == 2'd3;
					mac_ctl.dest  = {2'd3, cnt_q[3:2]};
				end
				default: begin
					cur_addr = cnt_q[3:0];
				end
			endcase
		end
	end

	assign cur_rd = cur_q[cur_addr];
	assign opd_rd = opd_q[opd_addr];

	tme_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.res    (mac_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_IDENTITY;
			cnt_q   <= '0;
			eq_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= command;
						cnt_q <= '0;
						eq_q  <= 1'b1;
						if (is_long) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if ((cmd_q == CMD_COMPARE) && (cur_rd != opd_rd)) begin
						eq_q <= 1'b0;
					end
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == run_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			read_q      <= '0;
			equal_q     <= 1'b0;
		end else begin
			if (accept && !is_long) begin
				out_valid_q <= 1'b1;
				read_q      <= (command == CMD_READ) ? elem_to_out(cur_rd) : '0;
				equal_q     <= 1'b0;
			end else if (finish) begin
				out_valid_q <= 1'b1;
				read_q      <= '0;
				equal_q     <= (cmd_q == CMD_COMPARE) && eq_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vec_q[0] <= in_to_elem(vec_x);
			vec_q[1] <= in_to_elem(vec_y);
			vec_q[2] <= in_to_elem(vec_z);
			vec_q[3] <= ELEM_ONE;
		end
		if (mac_res.valid && (cmd_q == CMD_PREMULT)) begin
			tmp_q[mac_res.dest] <= mac_res.value;
		end
	end

	// matrix storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				cur_q[i] <= '0;
				opd_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				unique case (command)
					CMD_IDENTITY: begin
						for (int i = 0; i < 16; i++) begin
							cur_q[i] <= ((i >> 2) == (i & 3)) ? ELEM_ONE : '0;
						end
					end
					CMD_WR_CUR: cur_q[idx] <= in_to_elem(value);
					CMD_WR_OPD: opd_q[idx] <= in_to_elem(value);
					CMD_COPY:   cur_q <= opd_q;
					default: ;
				endcase
			end
			if (mac_res.valid && (cmd_q != CMD_PREMULT)) begin
				cur_q[mac_res.dest] <= mac_res.value;
			end
			if (finish && (cmd_q == CMD_PREMULT)) begin
				cur_q <= tmp_q;
			end
		end
	end

endmodule

@@ dv/transform_matrix_4x4_engine_tb.sv @@
// Self-checking testbench for transform_matrix_4x4_engine: directed and random command
// words checked against a fixed-point matrix predictor, under varied idle/stall pressure.
// Depends on tme_pkg and the engine RTL.
`timescale 1ns / 100ps

module transform_matrix_4x4_engine_tb;
	import tme_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;
	localparam logic [3:0] CMD_SPARE_FIRST = 4'(CMD_COPY + 1);
	localparam logic [3:0] CMD_SPARE_LAST  = 4'hF;

	typedef struct packed {
		logic [IO_BITS-1:0] rd;
		logic               eq;
	} result_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [3:0]                command;
	logic [1:0]                row;
	logic [1:0]                col;
	logic signed [IO_BITS-1:0] value;
	logic signed [IO_BITS-1:0] vec_x;
	logic signed [IO_BITS-1:0] vec_y;
	logic signed [IO_BITS-1:0] vec_z;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [IO_BITS-1:0] read_value;
	logic                      matrices_equal;

	elem_t        current_elems [16];
	elem_t        operand_elems [16];
	result_word_t expected_results [$];
	int           mismatch_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           hold_requests;

	transform_matrix_4x4_engine DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.row            (row),
		.col            (col),
		.value          (value),
		.vec_x          (vec_x),
		.vec_y          (vec_y),
		.vec_z          (vec_z),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.matrices_equal (matrices_equal)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb: failure");
		$finish;
	end

	function automatic elem_t clamp_word(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = ELEM_MAX;
		lo = ELEM_MIN;
		if (v > hi) begin
			return ELEM_MAX;
		end else if (v < lo) begin
			return ELEM_MIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	// exact product, floor shift, then saturate
	function automatic elem_t fx_product(input elem_t a, input elem_t b);
		logic signed [63:0] wa;
		logic signed [63:0] wb;
		wa = a;
		wb = b;
		return clamp_word((wa * wb) >>> FRAC_BITS);
	endfunction

	task automatic apply_command(input logic [3:0] cmd, input logic [1:0] r, input logic [1:0] c,
			input elem_t val, input elem_t vx, input elem_t vy, input elem_t vz);
		result_word_t       res;
		elem_t              scratch [16];
		elem_t              factor [3];
		logic signed [63:0] acc;
		int                 idx;
		idx = 4 * r + c;
		factor[0] = vx;
		factor[1] = vy;
		factor[2] = vz;
		res = '0;
		case (cmd)
			CMD_IDENTITY: begin
				for (int i = 0; i < 16; i++)
					current_elems[i] = (i % 5 == 0) ? clamp_word(64'sd1 <<< FRAC_BITS) : '0;
			end
			CMD_WR_CUR: current_elems[idx] = val;
			CMD_WR_OPD: operand_elems[idx] = val;
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 4; j++)
						current_elems[4*i+j] = fx_product(current_elems[4*i+j], factor[i]);
			end
			CMD_XLATE: begin
				for (int j = 0; j < 4; j++) begin
					acc = current_elems[12+j];
					for (int i = 0; i < 3; i++)
						acc += fx_product(current_elems[4*i+j], factor[i]);
					current_elems[12+j] = clamp_word(acc);
				end
			end
			CMD_PREMULT: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) begin
						acc = 0;
						for (int k = 0; k < 4; k++)
							acc += fx_product(operand_elems[4*i+k], current_elems[4*k+j]);
						scratch[4*i+j] = clamp_word(acc);
					end
				current_elems = scratch;
			end
			CMD_READ: res.rd = current_elems[idx];
			CMD_COMPARE: res.eq = (current_elems == operand_elems);
			CMD_COPY: current_elems = operand_elems;
			default: ;
		endcase
		expected_results.push_back(res);
	endtask

	function automatic void note_mismatch(input string field, input logic [IO_BITS-1:0] exp_v,
			input logic [IO_BITS-1:0] act_v);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at %0t on %s: expected %h, got %h", $time, field, exp_v, act_v);
	endfunction

	always @(posedge clk) begin
		result_word_t exp_w;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected word", '0, read_value);
			end else begin
				exp_w = expected_results.pop_front();
				if (read_value !== exp_w.rd)
					note_mismatch("read_value", exp_w.rd, read_value);
				if (matrices_equal !== exp_w.eq)
					note_mismatch("matrices_equal", IO_BITS'(exp_w.eq),
						IO_BITS'(matrices_equal));
			end
		end
	end

	// receiver: random stall, or a long hold when one is requested
	initial begin
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_word(input logic [3:0] cmd, input logic [1:0] r, input logic [1:0] c,
			input logic [31:0] val, input logic [31:0] vx, input logic [31:0] vy,
			input logic [31:0] vz);
		int gap;
		in_valid <= 1'b1;
		command  <= cmd;
		row      <= r;
		col      <= c;
		value    <= val;
		vec_x    <= vx;
		vec_y    <= vy;
		vec_z    <= vz;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		apply_command(cmd, r, c, val, vx, vy, vz);
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_simple(input logic [3:0] cmd, input logic [1:0] r, input logic [1:0] c,
			input logic [31:0] val);
		send_word(cmd, r, c, val, $urandom, $urandom, $urandom);
	endtask

	task automatic wait_all_returned();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_fixed();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
			default: return $urandom_range(0, 32'h80000) - 32'h40000;
		endcase
	endfunction

	task automatic test_element_access();
		send_simple(CMD_WR_CUR, 0, 0, ELEM_MAX);
		send_simple(CMD_WR_CUR, 3, 3, ELEM_MIN);
		send_simple(CMD_READ, 0, 0, $urandom);
		send_simple(CMD_READ, 3, 3, $urandom);
		send_simple(CMD_WR_OPD, 2, 1, 32'h0001_8000);
		send_simple(CMD_READ, 2, 1, $urandom);
		send_simple(CMD_SPARE_LAST, 3, 3, $urandom);
		send_simple(CMD_SPARE_FIRST, 0, 0, $urandom);
		send_simple(CMD_READ, 3, 3, $urandom);
		wait_all_returned();
	endtask

	task automatic test_identity_copy_compare();
		send_simple(CMD_COMPARE, 0, 0, $urandom);
		send_simple(CMD_IDENTITY, 1, 2, $urandom);
		send_simple(CMD_READ, 1, 1, $urandom);
		send_simple(CMD_COPY, 0, 0, $urandom);
		send_simple(CMD_COMPARE, 0, 0, $urandom);
		send_simple(CMD_READ, 2, 1, $urandom);
		wait_all_returned();
	endtask

	task automatic test_scale_translate();
		send_simple(CMD_IDENTITY, 0, 0, $urandom);
		send_word(CMD_SCALE, 0, 0, $urandom, ELEM_MAX, ELEM_MIN, 32'h0002_0000);
		send_word(CMD_XLATE, 0, 0, $urandom, ELEM_MAX, ELEM_MIN, 32'hFFFE_8000);
		send_simple(CMD_READ, 3, 0, $urandom);
		send_simple(CMD_READ, 3, 1, $urandom);
		wait_all_returned();
	endtask

	task automatic test_premultiply();
		send_simple(CMD_WR_OPD, 0, 0, ELEM_MIN);
		send_simple(CMD_WR_OPD, 0, 1, ELEM_MAX);
		send_simple(CMD_PREMULT, 0, 0, $urandom);
		send_simple(CMD_READ, 0, 0, $urandom);
		send_simple(CMD_READ, 0, 1, $urandom);
		wait_all_returned();
	endtask

	// long receiver hold while words keep coming, so the engine stalls its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests++;
		for (int i = 0; i < 8; i++)
			send_simple((i % 2) ? CMD_READ : CMD_WR_CUR, $urandom, $urandom, $urandom);
		send_simple(CMD_PREMULT, 0, 0, $urandom);
		send_simple(CMD_COMPARE, 0, 0, $urandom);
		wait_all_returned();
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
		int pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 12)
				send_simple(CMD_WR_CUR, $urandom, $urandom, rand_fixed());
			else if (pick < 24)
				send_simple(CMD_WR_OPD, $urandom, $urandom, rand_fixed());
			else if (pick < 38)
				send_simple(CMD_READ, $urandom, $urandom, $urandom);
			else if (pick < 46)
				send_word(CMD_SCALE, $urandom, $urandom, $urandom,
					rand_fixed(), rand_fixed(), rand_fixed());
			else if (pick < 54)
				send_word(CMD_XLATE, $urandom, $urandom, $urandom,
					rand_fixed(), rand_fixed(), rand_fixed());
			else if (pick < 63)
				send_simple(CMD_PREMULT, $urandom, $urandom, $urandom);
			else if (pick < 70)
				send_simple(CMD_COMPARE, $urandom, $urandom, $urandom);
			else if (pick < 76)
				send_simple(CMD_COPY, $urandom, $urandom, $urandom);
			else if (pick < 84)
				send_simple(CMD_IDENTITY, $urandom, $urandom, $urandom);
			else if (pick < 92) begin
				send_simple(CMD_COPY, $urandom, $urandom, $urandom);
				if ($urandom_range(1))
					send_simple(CMD_WR_OPD, $urandom, $urandom, rand_fixed());
				send_simple(CMD_COMPARE, $urandom, $urandom, $urandom);
			end else if (pick < 96)
				send_simple($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST),
					$urandom, $urandom, $urandom);
			else
				send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
		wait_all_returned();
	endtask

	initial begin
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests = 0;
		for (int i = 0; i < 16; i++) begin
			current_elems[i] = '0;
			operand_elems[i] = '0;
		end
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		command  <= CMD_IDENTITY;
		row      <= '0;
		col      <= '0;
		value    <= '0;
		vec_x    <= '0;
		vec_y    <= '0;
		vec_z    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_element_access();
		test_identity_copy_compare();
		test_scale_translate();
		test_premultiply();
		test_backpressure();
		test_random_traffic(110, 0, 0);
		test_random_traffic(110, 63, 0);
		test_random_traffic(110, 0, 63);
		test_random_traffic(110, 12, 12);

		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
